@@ hw/rtl/grid_local_peak_finder_assert.svh @@
// Assertion macros used by the grid local peak finder checker
`ifndef GRID_LOCAL_PEAK_FINDER_ASSERT_SVH
`define GRID_LOCAL_PEAK_FINDER_ASSERT_SVH

// same-cycle implication on the clock named clock
`define GLPF_ASSERT_IMP(lbl, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on the clock named clock
`define GLPF_ASSERT_NXT(lbl, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/glpf_pkg.sv @@
// Types, widths and codes of the grid local peak finder
package glpf_pkg;

   localparam int MAX_COLS_DEF     = 1024;
   localparam int SAMPLE_BITS_DEF  = 16;

   localparam int ROW_BITS         = 16;
   localparam int COL_PORT_BITS    = 10;
   localparam int SAMPLE_PORT_BITS = 16;
   localparam int ROWS_REG_BITS    = 16;
   localparam int COLS_REG_BITS    = 11;
   localparam int CSR_DATA_BITS    = 16;
   localparam int CSR_INDEX_BITS   = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GRID_ROWS = 1'b0,
      CSR_GRID_COLS = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_SAMPLE = 1'b0,
      MODE_FLUSH  = 1'b1
   } mode_type;

   typedef struct packed {
      logic                go;
      logic                decide;
      logic                flush;
      logic                has_up;
      logic                has_down;
      logic                has_left;
      logic                has_right;
      logic [ROW_BITS-1:0] row;
   } step_type;

endpackage

@@ hw/rtl/glpf_channels.sv @@
// Request and response channel interfaces of the grid local peak finder
interface glpf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 mode;
   logic [glpf_pkg::SAMPLE_PORT_BITS-1:0] sample;

   modport source (output valid, output mode, output sample, input ready);
   modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface glpf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [glpf_pkg::ROW_BITS-1:0]      peak_row;
   logic [glpf_pkg::COL_PORT_BITS-1:0] peak_col;

   modport source (output valid, output peak_row, output peak_col, input ready);
   modport sink   (input valid, input peak_row, input peak_col, output ready);
endinterface

@@ hw/rtl/glpf_line_ram.sv @@
// Line buffer memory: one write port, two registered read ports
module glpf_line_ram #(
   parameter int DEPTH = glpf_pkg::MAX_COLS_DEF,
   parameter int WIDTH = 2 * glpf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int ENTRIES   = 1 << ADDR_BITS;

   logic [WIDTH-1:0] mem_ff [ENTRIES];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ hw/rtl/glpf_sequencer.sv @@
// Raster position counters, size registers and per-item step decode
module glpf_sequencer #(
   parameter int MAX_COLS  = glpf_pkg::MAX_COLS_DEF,
   parameter int DATA_BITS = glpf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [glpf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [glpf_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                  accept,
   input  logic                                  mode,
   input  logic [glpf_pkg::SAMPLE_PORT_BITS-1:0] sample,
   output glpf_pkg::step_type                    step,
   output logic [$clog2(MAX_COLS)-1:0]           col,
   output logic [DATA_BITS-1:0]                  smp,
   output logic [$clog2(MAX_COLS)-1:0]           rd_addr_a,
   output logic [$clog2(MAX_COLS)-1:0]           rd_addr_b
);

   localparam int COL_BITS = $clog2(MAX_COLS);
   localparam int CW = (COL_BITS + 1 > glpf_pkg::COLS_REG_BITS) ?
                       COL_BITS + 1 : glpf_pkg::COLS_REG_BITS;
   localparam int RW = glpf_pkg::ROWS_REG_BITS + 1;

   logic [glpf_pkg::ROWS_REG_BITS-1:0] grid_rows_ff, grid_rows_in;
   logic [glpf_pkg::COLS_REG_BITS-1:0] grid_cols_ff, grid_cols_in;
   logic [COL_BITS-1:0]                col_ff, col_in;
   logic [glpf_pkg::ROW_BITS-1:0]      row_ff, row_in;
   logic                               flush_ff, flush_in;

   logic [CW-1:0] cols_ext;
   logic [CW-1:0] eff_cols;
   logic [RW-1:0] eff_rows;
   logic [CW-1:0] col_next;
   logic [RW-1:0] row_next;
   logic          last_col;

   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      if (csr_we) begin
         unique case (glpf_pkg::csr_index_type'(csr_index))
            glpf_pkg::CSR_GRID_ROWS: begin
               grid_rows_in = csr_wdata[glpf_pkg::ROWS_REG_BITS-1:0];
            end
            glpf_pkg::CSR_GRID_COLS: begin
               grid_cols_in = csr_wdata[glpf_pkg::COLS_REG_BITS-1:0];
            end
         endcase
      end
   end

   always_comb begin
      cols_ext = CW'(grid_cols_ff);
      if (cols_ext == '0) begin
         eff_cols = CW'(1);
      end else if (cols_ext > CW'(MAX_COLS)) begin
         eff_cols = CW'(MAX_COLS);
      end else begin
         eff_cols = cols_ext;
      end
      eff_rows = (grid_rows_ff == '0) ? RW'(1) : RW'(grid_rows_ff);
      col_next = CW'(col_ff) + CW'(1);
      row_next = RW'(row_ff) + RW'(1);
      last_col = (col_next >= eff_cols);
   end

   always_comb begin
      step           = '0;
      step.has_left  = (col_ff != '0);
      step.has_right = !last_col;
      step.has_up    = (row_ff > glpf_pkg::ROW_BITS'(1));
      col_in         = col_ff;
      row_in         = row_ff;
      flush_in       = flush_ff;
      unique case (glpf_pkg::mode_type'(mode))
         glpf_pkg::MODE_SAMPLE: begin
            step.go       = !flush_ff;
            step.decide   = (row_ff != '0);
            step.has_down = 1'b1;
            step.row      = row_ff - glpf_pkg::ROW_BITS'(1);
            if (accept && !flush_ff) begin
               if (last_col) begin
                  col_in = '0;
                  row_in = row_next[glpf_pkg::ROW_BITS-1:0];
                  if (row_next >= eff_rows) begin
                     flush_in = 1'b1;
                  end
               end else begin
                  col_in = col_next[COL_BITS-1:0];
               end
            end
         end
         glpf_pkg::MODE_FLUSH: begin
            step.go     = flush_ff;
            step.decide = 1'b1;
            step.flush  = 1'b1;
            step.row    = (row_ff != '0) ? row_ff - glpf_pkg::ROW_BITS'(1) : '0;
            if (accept && flush_ff) begin
               if (last_col) begin
                  col_in   = '0;
                  row_in   = '0;
                  flush_in = 1'b0;
               end else begin
                  col_in = col_next[COL_BITS-1:0];
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= glpf_pkg::ROWS_REG_BITS'(1);
         grid_cols_ff <= glpf_pkg::COLS_REG_BITS'(1);
         col_ff       <= '0;
         row_ff       <= '0;
         flush_ff     <= 1'b0;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         flush_ff     <= flush_in;
      end
   end

   assign col       = col_ff;
   assign smp       = sample[DATA_BITS-1:0];
   assign rd_addr_a = col_ff;
   assign rd_addr_b = col_next[COL_BITS-1:0];

endmodule

@@ hw/rtl/glpf_judge.sv @@
// Decision stage: forwarding, neighbour compare, write-back and result register
module glpf_judge #(
   parameter int MAX_COLS  = glpf_pkg::MAX_COLS_DEF,
   parameter int DATA_BITS = glpf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  glpf_pkg::step_type                 step,
   input  logic [$clog2(MAX_COLS)-1:0]        col,
   input  logic [DATA_BITS-1:0]               smp,
   input  logic [$clog2(MAX_COLS)-1:0]        rd_addr_a,
   input  logic [$clog2(MAX_COLS)-1:0]        rd_addr_b,
   input  logic [2*DATA_BITS-1:0]             rd_data_a,
   input  logic [2*DATA_BITS-1:0]             rd_data_b,
   output logic                               rd_en,
   output logic                               wr_en,
   output logic [$clog2(MAX_COLS)-1:0]        wr_addr,
   output logic [2*DATA_BITS-1:0]             wr_data,
   output logic                               ready,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [glpf_pkg::ROW_BITS-1:0]      peak_row,
   output logic [glpf_pkg::COL_PORT_BITS-1:0] peak_col
);

   localparam int COL_BITS   = $clog2(MAX_COLS);
   localparam int ENTRY_BITS = 2 * DATA_BITS;

   logic                               s1_valid_ff, s1_valid_in;
   glpf_pkg::step_type                 s1_step_ff, s1_step_in;
   logic [COL_BITS-1:0]                s1_col_ff, s1_col_in;
   logic [DATA_BITS-1:0]               s1_smp_ff, s1_smp_in;
   logic                               fwd_a_ff, fwd_a_in;
   logic                               fwd_b_ff, fwd_b_in;
   logic [ENTRY_BITS-1:0]              fwd_data_ff, fwd_data_in;
   logic [DATA_BITS-1:0]               left_ff, left_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [glpf_pkg::ROW_BITS-1:0]      rsp_row_ff, rsp_row_in;
   logic [glpf_pkg::COL_PORT_BITS-1:0] rsp_col_ff, rsp_col_in;

   logic                  out_free;
   logic                  leave;
   logic                  load;
   logic [ENTRY_BITS-1:0] entry_a;
   logic [ENTRY_BITS-1:0] entry_b;
   logic [DATA_BITS-1:0]  centre;
   logic [DATA_BITS-1:0]  up;
   logic [DATA_BITS-1:0]  right;
   logic                  peak;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign leave    = s1_valid_ff && out_free;
   assign ready    = !s1_valid_ff || out_free;
   assign load     = accept && step.go;
   assign rd_en    = load;

   always_comb begin
      entry_a = fwd_a_ff ? fwd_data_ff : rd_data_a;
      entry_b = fwd_b_ff ? fwd_data_ff : rd_data_b;
      centre  = entry_a[DATA_BITS-1:0];
      up      = entry_a[ENTRY_BITS-1:DATA_BITS];
      right   = entry_b[DATA_BITS-1:0];
      peak    = s1_step_ff.decide
                && !(s1_step_ff.has_up    && (centre < up))
                && !(s1_step_ff.has_down  && (centre < s1_smp_ff))
                && !(s1_step_ff.has_left  && (centre < left_ff))
                && !(s1_step_ff.has_right && (centre < right));
   end

   assign wr_en   = leave;
   assign wr_addr = s1_col_ff;
   assign wr_data = {centre, s1_step_ff.flush ? centre : s1_smp_ff};

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_step_in   = s1_step_ff;
      s1_col_in    = s1_col_ff;
      s1_smp_in    = s1_smp_ff;
      fwd_a_in     = fwd_a_ff;
      fwd_b_in     = fwd_b_ff;
      fwd_data_in  = fwd_data_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;

      if (leave) begin
         s1_valid_in  = 1'b0;
         left_in      = centre;
         rsp_valid_in = peak;
         rsp_row_in   = s1_step_ff.row;
         rsp_col_in   = glpf_pkg::COL_PORT_BITS'(s1_col_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (load) begin
         s1_valid_in = 1'b1;
         s1_step_in  = step;
         s1_col_in   = col;
         s1_smp_in   = smp;
         fwd_a_in    = wr_en && (wr_addr == rd_addr_a);
         fwd_b_in    = wr_en && (wr_addr == rd_addr_b);
         fwd_data_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_step_ff  <= s1_step_in;
      s1_col_ff   <= s1_col_in;
      s1_smp_ff   <= s1_smp_in;
      fwd_a_ff    <= fwd_a_in;
      fwd_b_ff    <= fwd_b_in;
      fwd_data_ff <= fwd_data_in;
      left_ff     <= left_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign peak_row  = rsp_row_ff;
   assign peak_col  = rsp_col_ff;

endmodule

@@ hw/rtl/grid_local_peak_finder.sv @@
// Grid local peak finder top level
// Takes one grid sample (or bottom-row flush tick) per clock, back to back, and
// reports 4-neighbour local maxima in raster order as row and column. A result
// passes, after the transfer that decides it, first through the registered read
// of the line RAM, which keeps the two most recent rows of each column in one
// entry, and then through the output register. Back-to-back writes and
// reads of the same column are forwarded, so narrow grids keep the same rate.
// Only a stalled result holds up the input. After the last sample of a grid,
// send one flush item per column; samples during the flush and flushes before
// the grid is complete are dropped without a result. The line RAM needs no
// clearing pass after reset. Write grid_rows (index 0) and grid_cols (index 1)
// only while the block is idle.
module grid_local_peak_finder #(
   parameter int MAX_COLS    = glpf_pkg::MAX_COLS_DEF,
   parameter int SAMPLE_BITS = glpf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   glpf_req_if.sink                            req_if,
   glpf_rsp_if.source                          rsp_if,
   input  logic                                csr_we,
   input  logic [glpf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [glpf_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int COL_BITS  = $clog2(MAX_COLS);
   localparam int DATA_BITS = (SAMPLE_BITS < glpf_pkg::SAMPLE_PORT_BITS) ?
                              SAMPLE_BITS : glpf_pkg::SAMPLE_PORT_BITS;

   glpf_pkg::step_type      step;
   logic [COL_BITS-1:0]     col;
   logic [DATA_BITS-1:0]    smp;
   logic [COL_BITS-1:0]     rd_addr_a;
   logic [COL_BITS-1:0]     rd_addr_b;
   logic [2*DATA_BITS-1:0]  rd_data_a;
   logic [2*DATA_BITS-1:0]  rd_data_b;
   logic                    rd_en;
   logic                    wr_en;
   logic [COL_BITS-1:0]     wr_addr;
   logic [2*DATA_BITS-1:0]  wr_data;
   logic                    ready;
   logic                    accept;

   assign req_if.ready = ready;
   assign accept       = req_if.valid && ready;

   glpf_sequencer #(
      .MAX_COLS  (MAX_COLS),
      .DATA_BITS (DATA_BITS)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .mode      (req_if.mode),
      .sample    (req_if.sample),
      .step      (step),
      .col       (col),
      .smp       (smp),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b)
   );

   glpf_line_ram #(
      .DEPTH (MAX_COLS),
      .WIDTH (2 * DATA_BITS)
   ) u_line_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   glpf_judge #(
      .MAX_COLS  (MAX_COLS),
      .DATA_BITS (DATA_BITS)
   ) u_judge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .step      (step),
      .col       (col),
      .smp       (smp),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .rd_en     (rd_en),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .ready     (ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .peak_row  (rsp_if.peak_row),
      .peak_col  (rsp_if.peak_col)
   );

endmodule

@@ hw/rtl/glpf_checker.sv @@
// Port-level assertion checker for the grid local peak finder, with its bind
`include "grid_local_peak_finder_assert.svh"

module glpf_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [glpf_pkg::ROW_BITS-1:0]      rsp_row,
   input logic [glpf_pkg::COL_PORT_BITS-1:0] rsp_col
);

   `GLPF_ASSERT_NXT(a_reset_clears_rsp, 1'b0, reset, !rsp_valid, "result valid after reset")

   `GLPF_ASSERT_NXT(a_rsp_holds, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_row) && $stable(rsp_col), "stalled result changed")

   `GLPF_ASSERT_IMP(a_stall_only_on_rsp, reset, !req_ready, rsp_valid && !rsp_ready, "input stalled without a stalled result")

   `GLPF_ASSERT_IMP(a_rsp_has_cause, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without a transfer two cycles earlier")

endmodule

bind grid_local_peak_finder glpf_checker u_glpf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_row   (rsp_if.peak_row),
   .rsp_col   (rsp_if.peak_col)
);

@@ bench/grid_peak_checker.sv @@
`timescale 1ns / 1ps
// Peak checker: follows the grid state, predicts each peak and compares it with the output
module grid_peak_checker
   import glpf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   glpf_req_if                       req_mon,
   glpf_rsp_if                       rsp_mon,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int unsigned               mismatch_count,
   output int unsigned               peaks_waiting,
   output int unsigned               peaks_matched
);
   localparam int unsigned LINE_DEPTH = MAX_COLS_DEF;

   typedef struct packed {
      logic [ROW_BITS-1:0]      row;
      logic [COL_PORT_BITS-1:0] col;
   } peak_type;

   logic [SAMPLE_PORT_BITS-1:0] above_line [LINE_DEPTH];
   logic [SAMPLE_PORT_BITS-1:0] recent_line [LINE_DEPTH];
   int unsigned                 row_pos;
   int unsigned                 col_pos;
   logic                        bottom_flush;
   logic [ROWS_REG_BITS-1:0]    rows_reg;
   logic [COLS_REG_BITS-1:0]    cols_reg;
   peak_type                    peak_q [$];

   task automatic report_mismatch(input string what);
      $display("%0t ns: MISMATCH %s", $realtime, what);
      mismatch_count++;
   endtask

   // compare against the existing neighbors, then shift the column down one row
   function automatic bit judge_position(input int unsigned row, input int unsigned col,
                                         input int unsigned cols, input bit has_below,
                                         input logic [SAMPLE_PORT_BITS-1:0] below);
      logic [SAMPLE_PORT_BITS-1:0] height;
      bit                          peak;
      height = recent_line[col];
      peak = 1'b1;
      if (row > 0 && height < above_line[col]) peak = 1'b0;
      if (has_below && height < below) peak = 1'b0;
      if (col > 0 && height < above_line[col - 1]) peak = 1'b0;
      if (col + 1 < cols && height < recent_line[col + 1]) peak = 1'b0;
      above_line[col] = height;
      return peak;
   endfunction

   task automatic step_grid(input mode_type kind, input logic [SAMPLE_PORT_BITS-1:0] height);
      int unsigned cols;
      int unsigned rows;
      int unsigned col;
      int unsigned peak_row;
      bit          peak;
      cols = (cols_reg == 0) ? 1 : cols_reg;
      if (cols > LINE_DEPTH) cols = LINE_DEPTH;
      rows = (rows_reg == 0) ? 1 : rows_reg;
      col = (col_pos >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_pos;
      peak = 1'b0;
      peak_row = 0;
      if (kind == MODE_SAMPLE) begin
         if (bottom_flush) return;
         if (row_pos > 0) begin
            peak_row = row_pos - 1;
            peak = judge_position(peak_row, col, cols, 1'b1, height);
         end else begin
            above_line[col] = recent_line[col];
         end
         recent_line[col] = height;
         if (col + 1 >= cols) begin
            col_pos = 0;
            if (row_pos + 1 >= rows) bottom_flush = 1'b1;
            row_pos = (row_pos + 1) & 32'hFFFF;
         end else begin
            col_pos = col + 1;
         end
      end else begin
         if (!bottom_flush) return;
         peak_row = (row_pos > 0) ? row_pos - 1 : 0;
         peak = judge_position(peak_row, col, cols, 1'b0, '0);
         if (col + 1 >= cols) begin
            col_pos = 0;
            row_pos = 0;
            bottom_flush = 1'b0;
         end else begin
            col_pos = col + 1;
         end
      end
      if (peak) peak_q.push_back('{row: peak_row[ROW_BITS-1:0], col: col[COL_PORT_BITS-1:0]});
   endtask

   always @(posedge clock) begin : watch
      peak_type want;
      if (reset) begin
         foreach (above_line[i]) begin
            above_line[i] = '0;
            recent_line[i] = '0;
         end
         row_pos = 0;
         col_pos = 0;
         bottom_flush = 1'b0;
         rows_reg = 1;
         cols_reg = 1;
         peak_q.delete();
         mismatch_count = 0;
         peaks_waiting = 0;
         peaks_matched = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_ROWS: rows_reg = csr_wdata[ROWS_REG_BITS-1:0];
               CSR_GRID_COLS: cols_reg = csr_wdata[COLS_REG_BITS-1:0];
            endcase
         end
         if (req_mon.valid && req_mon.ready) step_grid(mode_type'(req_mon.mode), req_mon.sample);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (peak_q.size() == 0) begin
               report_mismatch($sformatf("peak at row %0d col %0d with none predicted",
                                         rsp_mon.peak_row, rsp_mon.peak_col));
            end else begin
               want = peak_q.pop_front();
               if (rsp_mon.peak_row !== want.row)
                  report_mismatch($sformatf("peak_row %0d, predicted %0d (col %0d)",
                                            rsp_mon.peak_row, want.row, want.col));
               if (rsp_mon.peak_col !== want.col)
                  report_mismatch($sformatf("peak_col %0d, predicted %0d (row %0d)",
                                            rsp_mon.peak_col, want.col, want.row));
               peaks_matched++;
            end
         end
         peaks_waiting = peak_q.size();
      end
   end

endmodule

@@ bench/grid_local_peak_finder_tb.sv @@
`timescale 1ns / 1ps
// Testbench top: streams grids into the peak finder, applies the checker and gives the verdict
module grid_local_peak_finder_tb;
   import glpf_pkg::*;

   localparam int unsigned QUIET_LIMIT   = 1000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned RANDOM_ITEMS  = 800;
   localparam int unsigned CALM_ITEMS    = 150;

   typedef enum int unsigned {
      HEIGHT_ANY,
      HEIGHT_LOW,
      HEIGHT_RAILS,
      HEIGHT_TOP
   } height_style_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   bit                        idling_on;
   int unsigned               fail_count;
   int unsigned               pending_peaks;
   int unsigned               peaks_checked;
   int unsigned               quiet_cycles;
   int unsigned               grid_items;
   int unsigned               dropped_items;
   int unsigned               grids_run;
   int unsigned               widest_grid;
   int unsigned               grid_rows_now;
   int unsigned               grid_cols_now;
   logic [CSR_DATA_BITS-1:0]  cols_word;

   glpf_req_if req_ch();
   glpf_rsp_if rsp_ch();

   grid_local_peak_finder i_dut (
      .clock,
      .reset,
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we,
      .csr_index,
      .csr_wdata
   );

   grid_peak_checker i_checker (
      .clock,
      .reset,
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_we,
      .csr_index,
      .csr_wdata,
      .mismatch_count (fail_count),
      .peaks_waiting  (pending_peaks),
      .peaks_matched  (peaks_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side: random stall bursts while idling is on
   initial begin
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (stall == 0 && idling_on && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 15);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("No transfer for %0d cycles", quiet_cycles);
         $display("grid_local_peak_finder test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [SAMPLE_PORT_BITS-1:0] pick_height(input height_style_type style);
      case (style)
         HEIGHT_ANY:   return SAMPLE_PORT_BITS'($urandom);
         HEIGHT_LOW:   return SAMPLE_PORT_BITS'($urandom_range(0, 3));
         HEIGHT_RAILS: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default:      return 16'hFFFC | SAMPLE_PORT_BITS'($urandom_range(0, 3));
      endcase
   endfunction

   task automatic send_item(input mode_type kind, input logic [SAMPLE_PORT_BITS-1:0] height,
                            input bit dropped);
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.mode   <= kind;
      req_ch.sample <= height;
      @(negedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
      if (dropped) dropped_items++;
      else grid_items++;
   endtask

   // hold off the sender until every predicted peak has come out
   task automatic drain_peaks();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_peaks != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_grid_shape(input logic [CSR_DATA_BITS-1:0] rows_word,
                                  input logic [CSR_DATA_BITS-1:0] cols_in);
      csr_we    <= 1'b1;
      csr_index <= CSR_GRID_ROWS;
      csr_wdata <= rows_word;
      @(posedge clock);
      csr_index <= CSR_GRID_COLS;
      csr_wdata <= cols_in;
      @(posedge clock);
      csr_we <= 1'b0;
      cols_word = cols_in;
      grid_rows_now = (rows_word == 0) ? 1 : rows_word;
      grid_cols_now = (cols_in[COLS_REG_BITS-1:0] == 0) ? 1 : cols_in[COLS_REG_BITS-1:0];
      if (grid_cols_now > MAX_COLS_DEF) grid_cols_now = MAX_COLS_DEF;
      if (grid_cols_now > widest_grid) widest_grid = grid_cols_now;
   endtask

   task automatic run_grid();
      int unsigned      rows_total;
      int unsigned      row;
      int unsigned      col;
      height_style_type style;
      rows_total = grid_rows_now;
      style = height_style_type'($urandom_range(0, 3));
      row = 0;
      while (row < rows_total) begin
         if (row != 0 && $urandom_range(0, 5) == 0) begin
            drain_peaks();
            load_grid_shape(CSR_DATA_BITS'($urandom_range(0, rows_total + 2)), cols_word);
            rows_total = (grid_rows_now > row + 1) ? grid_rows_now : row + 1;
         end
         for (col = 0; col < grid_cols_now; col++) begin
            if ($urandom_range(0, 24) == 0)
               send_item(MODE_FLUSH, SAMPLE_PORT_BITS'($urandom), 1'b1);
            send_item(MODE_SAMPLE, pick_height(style), 1'b0);
         end
         row++;
      end
      for (col = 0; col < grid_cols_now; col++) begin
         if ($urandom_range(0, 24) == 0)
            send_item(MODE_SAMPLE, SAMPLE_PORT_BITS'($urandom), 1'b1);
         send_item(MODE_FLUSH, SAMPLE_PORT_BITS'($urandom), 1'b0);
      end
      grids_run++;
   endtask

   initial begin
      int unsigned              start_items;
      bit                       first_grid;
      logic [CSR_DATA_BITS-1:0] rows_pick;
      logic [CSR_DATA_BITS-1:0] cols_pick;
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_index     <= CSR_GRID_ROWS;
      csr_wdata     <= '0;
      req_ch.valid  <= 1'b0;
      req_ch.mode   <= MODE_SAMPLE;
      req_ch.sample <= '0;
      idling_on     = 1'b0;
      grid_items    = 0;
      dropped_items = 0;
      grids_run     = 0;
      widest_grid   = 1;
      grid_rows_now = 1;
      grid_cols_now = 1;
      cols_word     = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // 1x1 grid from reset values, with an early flush and a sample during the flush
      send_item(MODE_FLUSH, 16'hFFFF, 1'b1);
      send_item(MODE_SAMPLE, 16'h0000, 1'b0);
      send_item(MODE_SAMPLE, 16'hFFFF, 1'b1);
      send_item(MODE_FLUSH, 16'h0000, 1'b0);

      // single row, zero rows acting as one
      drain_peaks();
      load_grid_shape(16'd0, 16'd3);
      send_item(MODE_SAMPLE, 16'hFFFF, 1'b0);
      send_item(MODE_SAMPLE, 16'h0000, 1'b0);
      send_item(MODE_SAMPLE, 16'hFFFF, 1'b0);
      repeat (3) send_item(MODE_FLUSH, 16'h0000, 1'b0);

      // single column, zero columns acting as one, equal neighbors
      drain_peaks();
      load_grid_shape(16'd3, 16'd0);
      send_item(MODE_SAMPLE, 16'd5, 1'b0);
      send_item(MODE_SAMPLE, 16'd5, 1'b0);
      send_item(MODE_SAMPLE, 16'd7, 1'b0);
      send_item(MODE_FLUSH, 16'h0000, 1'b0);

      // largest row count, then shrink both sizes in the middle of a row
      drain_peaks();
      load_grid_shape(16'hFFFF, 16'd3);
      send_item(MODE_SAMPLE, 16'd1, 1'b0);
      send_item(MODE_SAMPLE, 16'd2, 1'b0);
      send_item(MODE_SAMPLE, 16'd3, 1'b0);
      send_item(MODE_SAMPLE, 16'd4, 1'b0);
      drain_peaks();
      load_grid_shape(16'd2, 16'd1);
      send_item(MODE_SAMPLE, 16'd9, 1'b0);
      send_item(MODE_FLUSH, 16'h0000, 1'b0);

      // column register above the line depth, then narrow the row past its position
      idling_on = 1'b1;
      drain_peaks();
      load_grid_shape(16'd0, 16'h07FF);
      repeat (24) send_item(MODE_SAMPLE, pick_height(HEIGHT_LOW), 1'b0);
      drain_peaks();
      load_grid_shape(16'd0, 16'd6);
      send_item(MODE_SAMPLE, pick_height(HEIGHT_LOW), 1'b0);
      repeat (6) send_item(MODE_FLUSH, 16'h0000, 1'b0);
      grids_run++;

      start_items = grid_items;
      first_grid = 1'b1;
      while (grid_items - start_items < RANDOM_ITEMS) begin
         idling_on = (grid_items - start_items + CALM_ITEMS < RANDOM_ITEMS) &&
                     ($urandom_range(0, 3) != 0);
         if (first_grid || $urandom_range(0, 2) == 0) begin
            rows_pick = ($urandom_range(0, 9) == 0) ? 16'd0 :
                        CSR_DATA_BITS'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 4));
            cols_pick = ($urandom_range(0, 11) == 0) ? 16'd0 :
                        CSR_DATA_BITS'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8));
            drain_peaks();
            load_grid_shape(rows_pick, cols_pick);
            first_grid = 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            drain_peaks();
         end
         run_grid();
      end

      idling_on = 1'b0;
      drain_peaks();
      repeat (8) @(posedge clock);
      $display("Ran %0d grids: %0d grid transfers, %0d dropped transfers, widest grid %0d columns",
               grids_run, grid_items, dropped_items, widest_grid);
      $display("Checked %0d peaks, %0d mismatches, %0d peaks outstanding",
               peaks_checked, fail_count, pending_peaks);
      if (fail_count == 0 && pending_peaks == 0)
         $display("grid_local_peak_finder test passed");
      else
         $display("grid_local_peak_finder test failed");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/glpf_pkg.sv
hw/rtl/glpf_channels.sv
hw/rtl/glpf_line_ram.sv
hw/rtl/glpf_sequencer.sv
hw/rtl/glpf_judge.sv
hw/rtl/grid_local_peak_finder.sv
hw/rtl/glpf_checker.sv
bench/grid_peak_checker.sv
bench/grid_local_peak_finder_tb.sv
